// File: hdl/lmls_pkg.sv
// ----------------------------------------------------------------------------
// lmls_pkg
// Shared types, constants and access-form tables for the linear memory
// load/store core.
// ----------------------------------------------------------------------------
package lmls_pkg;

  localparam int MAX_PAGES  = 1;
  localparam int PAGE_BYTES = 65536;
  localparam int MEM_BYTES  = MAX_PAGES * PAGE_BYTES;
  localparam int ADDR_BITS  = $clog2(MEM_BYTES);
  localparam int LANES      = 8;
  localparam int LANE_BITS  = $clog2(LANES);
  localparam int ROW_BITS   = ADDR_BITS - LANE_BITS;
  localparam int ROWS       = MEM_BYTES / LANES;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic REG_MEMORY_PAGES     = 1'b0;
  localparam logic REG_BOUNDS_CHECK_OFF = 1'b1;

  localparam logic [3:0] LOAD_KINDS  = 4'd14;
  localparam logic [3:0] STORE_KINDS = 4'd9;

  localparam logic [1:0] VT_I32 = 2'd0;
  localparam logic [1:0] VT_I64 = 2'd1;
  localparam logic [1:0] VT_F32 = 2'd2;
  localparam logic [1:0] VT_F64 = 2'd3;

  typedef logic [LANES-1:0][7:0] lane_data_t;

  // Per-access information carried from the bank access into result forming.
  typedef struct packed {
    logic                 zero;
    logic [LANE_BITS-1:0] lane0;
    logic [3:0]           len;
    logic                 sext;
    logic [1:0]           vtype;
    logic                 fault;
  } access_info_t;

  function automatic logic [3:0] load_len(input logic [3:0] kind);
    logic [3:0] len;
    unique case (kind)
      4'd0, 4'd2, 4'd12, 4'd13:       len = 4'd4;
      4'd1, 4'd3:                     len = 4'd8;
      4'd4, 4'd5, 4'd8, 4'd9:         len = 4'd1;
      4'd6, 4'd7, 4'd10, 4'd11:       len = 4'd2;
      default:                        len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] load_vtype(input logic [3:0] kind);
    logic [1:0] vt;
    unique case (kind)
      4'd1, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13: vt = VT_I64;
      4'd2:                                         vt = VT_F32;
      4'd3:                                         vt = VT_F64;
      default:                                      vt = VT_I32;
    endcase
    return vt;
  endfunction

  function automatic logic load_signed(input logic [3:0] kind);
    return (kind == 4'd4) || (kind == 4'd6) || (kind == 4'd8) ||
           (kind == 4'd10) || (kind == 4'd12);
  endfunction

  function automatic logic [3:0] store_len(input logic [3:0] kind);
    logic [3:0] len;
    unique case (kind)
      4'd0, 4'd2, 4'd8: len = 4'd4;
      4'd1, 4'd3:       len = 4'd8;
      4'd4, 4'd6:       len = 4'd1;
      4'd5, 4'd7:       len = 4'd2;
      default:          len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/lmls_byte_bank.sv
// ----------------------------------------------------------------------------
// lmls_byte_bank
// One byte lane of the linear memory: single-port synchronous RAM with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module lmls_byte_bank (
  input  logic                          clk,
  input  logic                          read_enable,
  input  logic                          write_enable,
  input  logic [lmls_pkg::ROW_BITS-1:0] row,
  input  logic [7:0]                    write_data,
  output logic [7:0]                    read_data
);
  import lmls_pkg::*;

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[row] <= write_data;
    end
    if (read_enable) begin
      read_data <= mem[row];
    end
  end

endmodule

// File: hdl/lmls_align.sv
// ----------------------------------------------------------------------------
// lmls_align
// Rotate the bank read data into little-endian byte order, trim it to the
// access length and zero- or sign-extend it.
// ----------------------------------------------------------------------------
module lmls_align (
  input  lmls_pkg::lane_data_t   lane_data,
  input  lmls_pkg::access_info_t info,
  output logic [63:0]            value
);
  import lmls_pkg::*;

  logic [LANES-1:0][7:0] bytes;
  logic [63:0]           raw;
  logic [63:0]           ext;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      bytes[i] = lane_data[info.lane0 + LANE_BITS'(i)];
    end
    raw = bytes;

    unique case (info.len)
      4'd1:    ext = info.sext ? {{56{raw[7]}},  raw[7:0]}  : {56'd0, raw[7:0]};
      4'd2:    ext = info.sext ? {{48{raw[15]}}, raw[15:0]} : {48'd0, raw[15:0]};
      4'd4:    ext = info.sext ? {{32{raw[31]}}, raw[31:0]} : {32'd0, raw[31:0]};
      4'd8:    ext = raw;
      default: ext = 64'd0;
    endcase

    // Narrow value types keep the upper word clear.
    if (info.vtype == VT_I32 || info.vtype == VT_F32) begin
      ext[63:32] = 32'd0;
    end

    value = info.zero ? 64'd0 : ext;
  end

endmodule

// File: hdl/linear_memory_load_store_core.sv
// ----------------------------------------------------------------------------
// linear_memory_load_store_core
// Stages: bank read (data registered with the access info), output register.
// Throughput: one transaction per cycle while the output is not stalled; the
// eight byte-lane banks serve any 1..8 byte access at once.
// Reset: registers return to one page with bounds checking on; memory
// contents are not cleared (undefined until written).
// ----------------------------------------------------------------------------
module linear_memory_load_store_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_enable,
  input  logic        cfg_index,
  input  logic        cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [3:0]  access_kind,
  input  logic [31:0] address,
  input  logic [31:0] offset,
  input  logic [63:0] store_value,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] load_value,
  output logic [1:0]  result_type,
  output logic        fault
);
  import lmls_pkg::*;

  // Configuration registers.
  logic memory_pages;
  logic bounds_check_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_pages     <= 1'b1;
      bounds_check_off <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_MEMORY_PAGES:     memory_pages     <= cfg_data;
        REG_BOUNDS_CHECK_OFF: bounds_check_off <= cfg_data;
      endcase
    end
  end

  // Pipeline control: the bank read stage feeds the output register. Advance
  // the read stage whenever the output register is empty or being taken.
  logic s1_valid;
  logic advance;
  logic accept;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Decode the access and check bounds.
  logic [33:0]          mem_size;
  logic                 is_load;
  logic                 kind_ok;
  logic [3:0]           len;
  logic [32:0]          ea;
  logic [33:0]          access_end;
  logic                 oob;
  logic                 blocked;
  logic [ADDR_BITS-1:0] byte_addr;
  logic                 do_write;
  access_info_t         info_next;

  always_comb begin
    mem_size = memory_pages ? 34'(MEM_BYTES) : 34'd0;
    is_load  = (operation == OP_LOAD);
    kind_ok  = is_load ? (access_kind < LOAD_KINDS) : (access_kind < STORE_KINDS);
    len      = is_load ? load_len(access_kind) : store_len(access_kind);

    // Loads add the offset with a 32-bit carry check; stores use address alone.
    ea         = is_load ? ({1'b0, address} + {1'b0, offset}) : {1'b0, address};
    access_end = {1'b0, ea} + {30'd0, len};
    oob        = ea[32] || (access_end > mem_size);
    blocked    = oob && !bounds_check_off;

    // In range or wrapped, the byte address is the low bits of the 32-bit
    // effective address.
    byte_addr = ea[ADDR_BITS-1:0];

    do_write = accept && !is_load && kind_ok && !blocked && memory_pages;

    info_next.lane0 = byte_addr[LANE_BITS-1:0];
    info_next.len   = len;
    info_next.sext  = load_signed(access_kind);
    info_next.vtype = (is_load && kind_ok) ? load_vtype(access_kind) : VT_I32;
    info_next.fault = kind_ok && blocked;
    info_next.zero  = !is_load || !kind_ok || blocked || !memory_pages;
  end

  // Byte-lane banks: lane b holds bytes whose address is b modulo the lane
  // count. Lanes below the start lane fall in the next row; row arithmetic
  // wraps with the memory. A lane takes the store byte whose position in the
  // value matches its distance from the start lane.
  lane_data_t lane_data;

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [LANE_BITS-1:0] byte_idx;
    logic [ROW_BITS-1:0]  row;
    logic                 lane_we;

    assign byte_idx = LANE_BITS'(b) - byte_addr[LANE_BITS-1:0];
    assign row      = byte_addr[ADDR_BITS-1:LANE_BITS]
                    + ROW_BITS'(LANE_BITS'(b) < byte_addr[LANE_BITS-1:0]);
    assign lane_we  = do_write && ({1'b0, byte_idx} < len);

    lmls_byte_bank u_bank (
      .clk          (clk),
      .read_enable  (accept),
      .write_enable (lane_we),
      .row          (row),
      .write_data   (store_value[{byte_idx, 3'b000} +: 8]),
      .read_data    (lane_data[b])
    );
  end

  // Read stage: hold access info alongside the bank read data.
  access_info_t s1_info;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info_next;
    end
  end

  // Form the result from the lane data.
  logic [63:0] aligned_value;

  lmls_align u_align (
    .lane_data (lane_data),
    .info      (s1_info),
    .value     (aligned_value)
  );

  // Output register: load when advancing, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      load_value  <= aligned_value;
      result_type <= s1_info.vtype;
      fault       <= s1_info.fault;
    end
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear memory load/store core. A generator
// fills a queue of load and store transactions. It only lets a load read
// bytes that an earlier store has written. A clocked driver offers them under
// random idling. A clocked monitor checks every result against a
// transaction-level predictor, which keeps its own byte image and register
// copy.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;

  // Load forms and store forms in opcode order.
  typedef enum logic [3:0] {
    LD_I32, LD_I64, LD_F32, LD_F64, LD_I32_8S, LD_I32_8U, LD_I32_16S, LD_I32_16U,
    LD_I64_8S, LD_I64_8U, LD_I64_16S, LD_I64_16U, LD_I64_32S, LD_I64_32U,
    LD_UNUSED
  } load_form_e;

  typedef enum logic [3:0] {
    ST_I32, ST_I64, ST_F32, ST_F64, ST_I32_8, ST_I32_16, ST_I64_8, ST_I64_16,
    ST_I64_32, ST_UNUSED = 4'd15
  } store_form_e;

  localparam int LOAD_BYTES [LOAD_KINDS] = '{4, 8, 4, 8, 1, 1, 2, 2, 1, 1, 2, 2, 4, 4};
  localparam logic [1:0] LOAD_TYPE [LOAD_KINDS] = '{
    VT_I32, VT_I64, VT_F32, VT_F64, VT_I32, VT_I32, VT_I32, VT_I32,
    VT_I64, VT_I64, VT_I64, VT_I64, VT_I64, VT_I64};
  localparam bit LOAD_SEXT [LOAD_KINDS] = '{0, 0, 0, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
  localparam int STORE_BYTES [STORE_KINDS] = '{4, 8, 4, 8, 1, 2, 1, 2, 4};

  typedef struct packed {
    logic        op;
    logic [3:0]  kind;
    logic [31:0] addr;
    logic [31:0] off;
    logic [63:0] sval;
  } mem_access_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  vtype;
    logic        fault;
  } mem_result_t;

  // DUT connections; every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic        cfg_index = REG_MEMORY_PAGES;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_LOAD;
  logic [3:0]  access_kind = '0;
  logic [31:0] address = '0;
  logic [31:0] offset = '0;
  logic [63:0] store_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] load_value;
  logic [1:0]  result_type;
  logic        fault;

  // Transactions waiting for the driver, and results waiting for the DUT.
  mem_access_t access_q [$];
  mem_result_t result_q [$];
  mem_access_t drv_access;
  bit          in_taken = 1'b0;

  // Predictor state: byte image plus its own copy of both registers.
  logic [7:0] mem_image [MEM_BYTES];
  bit         mdl_pages = 1'b1;
  bit         mdl_chk_off = 1'b0;

  // Generator view: register settings at generation time and which bytes a
  // store has already written (loads must never touch anything else).
  bit gen_pages = 1'b1;
  bit gen_chk_off = 1'b0;
  bit written_map [MEM_BYTES];

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_pending = 1'b0;
  int          hold_left = 0;
  int unsigned accesses_queued = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  linear_memory_load_store_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .access_kind      (access_kind),
    .address          (address),
    .offset           (offset),
    .store_value      (store_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .load_value       (load_value),
    .result_type      (result_type),
    .fault            (fault)
  );

  always #5 clk = ~clk;

  // Work out where an access lands. Return 1 when it reads or writes memory;
  // flt reports a bounds fault with checking on. A load adds the offset and
  // faults on a 32-bit carry; a store uses the base address alone. With
  // checking off the byte address wraps within the memory.
  function automatic bit mem_span(input logic op, input logic [3:0] kind,
                                  input logic [31:0] addr, input logic [31:0] off,
                                  input bit pages, input bit chk_off,
                                  output logic [ADDR_BITS-1:0] base,
                                  output int nbytes, output bit flt);
    longint ea;
    longint size;
    bit     oob;
    size = pages ? longint'(PAGE_BYTES) : 64'd0;
    nbytes = 0;
    flt = 1'b0;
    base = '0;
    if (op == OP_LOAD) begin
      if (kind >= LOAD_KINDS) return 1'b0;
      nbytes = LOAD_BYTES[kind];
      ea = longint'(addr) + longint'(off);
    end else begin
      if (kind >= STORE_KINDS) return 1'b0;
      nbytes = STORE_BYTES[kind];
      ea = longint'(addr);
    end
    oob = (ea > 64'hFFFF_FFFF) || (ea + nbytes > size);
    flt = oob && !chk_off;
    base = ea[ADDR_BITS-1:0];
    return !flt && (size != 0);
  endfunction

  // Expected result of one transaction; stores update the byte image.
  function automatic mem_result_t predict_access(input mem_access_t a);
    mem_result_t           r;
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  idx;
    logic [63:0]           v;
    int                    nbytes;
    bit                    flt;
    bit                    touch;
    r = '0;
    v = '0;
    touch = mem_span(a.op, a.kind, a.addr, a.off, mdl_pages, mdl_chk_off,
                     base, nbytes, flt);
    r.fault = flt;
    if (a.op == OP_LOAD && a.kind < LOAD_KINDS) r.vtype = LOAD_TYPE[a.kind];
    if (touch && a.op == OP_LOAD) begin
      for (int i = 0; i < nbytes; i++) begin
        idx = base + ADDR_BITS'(i);
        v[8*i +: 8] = mem_image[idx];
      end
      if (LOAD_SEXT[a.kind] && v[8*nbytes-1]) v = v | (~64'd0 << (8 * nbytes));
      if (r.vtype == VT_I32 || r.vtype == VT_F32) v[63:32] = '0;
      r.value = v;
    end else if (touch) begin
      for (int i = 0; i < nbytes; i++) begin
        idx = base + ADDR_BITS'(i);
        mem_image[idx] = a.sval[8*i +: 8];
      end
    end
    return r;
  endfunction

  // Queue one transaction and note which bytes a store will leave written.
  task automatic add_access(input logic op, input logic [3:0] kind,
                            input logic [31:0] addr, input logic [31:0] off,
                            input logic [63:0] sval);
    mem_access_t          a;
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] idx;
    int                   nbytes;
    bit                   flt;
    a.op = op;
    a.kind = kind;
    a.addr = addr;
    a.off = off;
    a.sval = sval;
    if (op == OP_STORE &&
        mem_span(op, kind, addr, off, gen_pages, gen_chk_off, base, nbytes, flt)) begin
      for (int i = 0; i < nbytes; i++) begin
        idx = base + ADDR_BITS'(i);
        written_map[idx] = 1'b1;
      end
    end
    access_q.push_back(a);
    accesses_queued++;
  endtask

  // Mostly valid forms, with a few unused kinds mixed in.
  function automatic logic [3:0] random_kind(input logic op);
    logic [3:0] limit;
    limit = (op == OP_LOAD) ? LOAD_KINDS : STORE_KINDS;
    if ($urandom_range(0, 99) < 6) return 4'($urandom_range(limit, 15));
    return 4'($urandom_range(0, limit - 1));
  endfunction

  // Aim at the bottom or top of memory so that loads find written bytes and
  // accesses straddle the end; upper bits are sometimes set to go far out.
  function automatic logic [31:0] pick_target();
    logic [15:0] lo;
    logic [15:0] hi;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: lo = 16'($urandom_range(0, 127));
      9, 10, 11, 12, 13, 14, 15: lo = 16'hFFFF - 16'($urandom_range(0, 127));
      default: lo = 16'($urandom);
    endcase
    hi = ($urandom_range(0, 99) < 85) ? 16'h0 : 16'($urandom);
    return {hi, lo};
  endfunction

  // Random mix of loads and stores. Retry a load until it only reads
  // written bytes (or never reaches memory); give up and store instead.
  task automatic add_random_accesses(input int count);
    logic [31:0]          ea;
    logic [31:0]          addr;
    logic [31:0]          off;
    logic [3:0]           kind;
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] idx;
    int                   nbytes;
    bit                   flt;
    bit                   ok;
    repeat (count) begin
      ok = 1'b0;
      if ($urandom_range(0, 99) < 55) begin
        for (int tries = 0; tries < 40 && !ok; tries++) begin
          kind = random_kind(OP_LOAD);
          ea = pick_target();
          case ($urandom_range(0, 9))
            0, 1, 2: off = '0;
            3, 4, 5, 6: off = $urandom_range(0, ea);
            default: off = $urandom;
          endcase
          addr = ea - off;
          ok = 1'b1;
          if (mem_span(OP_LOAD, kind, addr, off, gen_pages, gen_chk_off,
                       base, nbytes, flt)) begin
            for (int i = 0; i < nbytes; i++) begin
              idx = base + ADDR_BITS'(i);
              if (!written_map[idx]) ok = 1'b0;
            end
          end
        end
        if (ok) add_access(OP_LOAD, kind, addr, off, {$urandom, $urandom});
      end
      if (!ok) add_access(OP_STORE, random_kind(OP_STORE), pick_target(), $urandom,
                          {$urandom, $urandom});
    end
  endtask

  // Extremes of the fields, every form, and the fault and unused-kind cases.
  task automatic add_directed_accesses();
    // Fill a few bytes at the bottom and the last eight bytes of the page.
    add_access(OP_STORE, ST_I64, 32'd0, 32'd0, 64'hFEDC_BA98_8765_4321);
    add_access(OP_STORE, ST_F64, 32'h0000_FFF8, 32'hFFFF_FFFF, 64'hC3D2_E1F0_0F1E_2D3C);
    add_access(OP_STORE, ST_I32, 32'd8, 32'd0, 64'h1111_1111_8000_0001);
    add_access(OP_STORE, ST_F32, 32'd12, 32'd0, 64'h2222_2222_7FFF_FFFE);
    add_access(OP_STORE, ST_I32_8, 32'd16, 32'd0, 64'hFFFF_FFFF_FFFF_FF80);
    add_access(OP_STORE, ST_I32_16, 32'd17, 32'd0, 64'h0000_0000_0000_8001);
    add_access(OP_STORE, ST_I64_8, 32'd19, 32'd0, 64'h0000_0000_0000_007F);
    // Store running past the end of memory: fault, nothing written.
    add_access(OP_STORE, ST_I64_16, 32'h0000_FFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_access(OP_STORE, ST_I64_32, 32'd20, 32'd0, 64'h0000_0000_8000_00FF);
    // Every load form, with negative and positive sign bits.
    add_access(OP_LOAD, LD_I32, 32'd0, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I64, 32'd0, 32'h0000_FFF8, 64'd0);
    add_access(OP_LOAD, LD_F32, 32'd8, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_F64, 32'd4, 32'd4, 64'd0);
    add_access(OP_LOAD, LD_I32_8S, 32'd16, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I32_8U, 32'd16, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I32_16S, 32'd17, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I32_16U, 32'd17, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I64_8S, 32'd3, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I64_8U, 32'd19, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I64_16S, 32'd22, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I64_16U, 32'd22, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I64_32S, 32'd4, 32'd0, 64'd0);
    add_access(OP_LOAD, LD_I64_32U, 32'd20, 32'd0, 64'd0);
    // Carry out of the 32-bit address add, then a load ending past memory.
    add_access(OP_LOAD, LD_I64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    add_access(OP_LOAD, LD_F64, 32'h0000_FFFA, 32'd0, 64'd0);
    // Unused kinds give an all-zero result, even far out of bounds.
    add_access(OP_LOAD, LD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    add_access(OP_STORE, ST_UNUSED, 32'hFFFF_FFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Write both registers while the core is idle.
  task automatic set_config(input bit pages, input bit chk_off);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= REG_MEMORY_PAGES;
    cfg_data <= pages;
    @(negedge clk);
    cfg_index <= REG_BOUNDS_CHECK_OFF;
    cfg_data <= chk_off;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    gen_pages = pages;
    gen_chk_off = chk_off;
  endtask

  // Wait until every queued transaction has produced its result.
  task automatic drain();
    while (results_checked != accesses_queued) @(negedge clk);
  endtask

  // Input side at the rising edge: track register writes and predict every
  // accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      mdl_pages = 1'b1;
      mdl_chk_off = 1'b0;
      in_taken = 1'b0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_MEMORY_PAGES:     mdl_pages = cfg_data;
          REG_BOUNDS_CHECK_OFF: mdl_chk_off = cfg_data;
        endcase
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) result_q.push_back(predict_access(drv_access));
    end
  end

  // Driver: advance to the next transaction only once the current one was
  // taken; hold the payload while stalled. Idling is decided per cycle.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_access = access_q.pop_front();
        in_valid <= 1'b1;
        operation <= drv_access.op;
        access_kind <= drv_access.kind;
        address <= drv_access.addr;
        offset <= drv_access.off;
        store_value <= drv_access.sval;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off that backs the core up.
  always @(negedge clk) begin
    if (hold_pending) begin
      hold_left = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    mem_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (result_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending: load_value %h result_type %0d fault %0b",
                 $time, load_value, result_type, fault);
      end else begin
        want = result_q.pop_front();
        if (load_value !== want.value) begin
          mismatches++;
          $display("%0t: load_value expected %h actual %h", $time, want.value, load_value);
        end
        if (result_type !== want.vtype) begin
          mismatches++;
          $display("%0t: result_type expected %0d actual %0d", $time, want.vtype,
                   result_type);
        end
        if (fault !== want.fault) begin
          mismatches++;
          $display("%0t: fault expected %0b actual %0b", $time, want.fault, fault);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL linear_memory_load_store_core");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // One page, checking on, no idling: directed cases then random traffic.
    set_config(1'b1, 1'b0);
    send_idle_pct = 0;
    stall_pct = 0;
    add_directed_accesses();
    add_random_accesses(150);
    drain();

    // Checking off: out-of-range accesses wrap; sparse sender.
    set_config(1'b1, 1'b1);
    send_idle_pct = 86;
    stall_pct = 0;
    add_random_accesses(120);
    drain();

    // Zero pages, checking off: loads read zero, stores drop; heavy stall.
    set_config(1'b0, 1'b1);
    send_idle_pct = 0;
    stall_pct = 86;
    add_random_accesses(70);
    drain();

    // Zero pages, checking on: every valid access faults; light idling both sides.
    set_config(1'b0, 1'b0);
    send_idle_pct = 15;
    stall_pct = 15;
    add_random_accesses(60);
    drain();

    // Back to one page; hold the output off at first so the core fills up.
    // Contents written earlier must still be there.
    set_config(1'b1, 1'b0);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_pending = 1'b1;
    add_random_accesses(175);
    drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (result_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, result_q.size());
    end
    if (mismatches == 0) begin
      $display("PASS linear_memory_load_store_core");
    end else begin
      $display("FAIL linear_memory_load_store_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lmls_pkg.sv
hdl/lmls_byte_bank.sv
hdl/lmls_align.sv
hdl/linear_memory_load_store_core.sv
verif/tb.sv
